[design/swfh_pkg.sv]
// package for the switch forwarding block with feedback holdoff
// table sizes, configuration register codes, state encoding and mac constants
// no dependencies
package swfh_pkg;

	// table sizes
	localparam int ROUTE_ENTRIES   = 256;
	localparam int NUM_PORTS       = 16;
	localparam int HOLDOFF_ENTRIES = 16;

	localparam int ROUTE_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int HO_AW    = (HOLDOFF_ENTRIES > 1) ? $clog2(HOLDOFF_ENTRIES) : 1;

	// field widths
	localparam int MAC_W    = 48;
	localparam int LEN_W    = 16;
	localparam int HOST_W   = 8;
	localparam int PORT_W   = 4;
	localparam int TICK_W   = 32;
	localparam int SWIDX_W  = 8;
	localparam int CFG_W    = 32;
	localparam int CFG_IX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_SWITCH_INDEX    = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_FEEDBACK_LENGTH = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_HOLDOFF_TICKS   = 2'd2;

	// configuration reset values
	localparam logic [SWIDX_W-1:0] SWITCH_INDEX_RST    = 8'd0;
	localparam logic [LEN_W-1:0]   FEEDBACK_LENGTH_RST = 16'd1600;
	localparam logic [TICK_W-1:0]  HOLDOFF_TICKS_RST   = 32'd20000;

	// action codes
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_PACKET = 1'b1;

	// rewritten source mac: FF:FF:FF:FF:index:FF
	localparam logic [31:0] FB_MAC_HI = 32'hFFFF_FFFF;
	localparam logic [7:0]  FB_MAC_LO = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE
	} state_t;

endpackage

[design/switch_forward_with_feedback_holdoff.sv]
// switch egress block: route table, feedback source rewrite, per-destination holdoff
// depends on swfh_pkg
// single module, route ports and holdoff times held in synchronous memories

// Usage: a transaction is taken when start is high and busy is low. Its result is
// loaded into the result registers at the end of the decide state and stays for
// exactly one cycle with done high; the receiver cannot hold it off. A new start is
// accepted at the edge that ends that cycle; no item is taken while the last is in
// lookup or decide, due to the read-modify-write of the holdoff time memory: lookup
// searches the destination tags and reads the memories, decide compares the elapsed
// time and writes back, then the result is registered. Load items also produce one
// result, all zero. The route table needs no clearing pass after reset: its valid
// bits are flip-flops cleared at once. Configuration writes on cfg_we are taken at
// any edge and must only happen while the block is idle.
module switch_forward_with_feedback_holdoff
	import swfh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [MAC_W-1:0]    dest_mac,
	input  logic [MAC_W-1:0]    src_mac,
	input  logic [LEN_W-1:0]    pkt_length,
	input  logic [HOST_W-1:0]   host_id,
	input  logic [PORT_W-1:0]   route_port,
	input  logic [TICK_W-1:0]   now_ticks,
	// result side
	output logic                done,
	output logic                forwarded,
	output logic [PORT_W-1:0]   out_port,
	output logic                is_feedback,
	output logic                held_off,
	output logic [MAC_W-1:0]    out_src_mac
);

	// configuration registers
	logic [SWIDX_W-1:0] switch_index_q;
	logic [LEN_W-1:0]   feedback_length_q;
	logic [TICK_W-1:0]  holdoff_ticks_q;

	// control
	state_t state_q, state_d;
	logic   accept;

	// transaction captured at accept
	logic              action_s1;
	logic [MAC_W-1:0]  dest_mac_s1;
	logic [MAC_W-1:0]  src_mac_s1;
	logic [LEN_W-1:0]  pkt_length_s1;
	logic [HOST_W-1:0] host_id_s1;
	logic [PORT_W-1:0] route_port_s1;
	logic [TICK_W-1:0] now_ticks_s1;

	// route table: valid bits in flops, port numbers in a memory
	logic [ROUTE_ENTRIES-1:0] route_vld_q;
	logic [PORT_W-1:0]        route_mem [ROUTE_ENTRIES];
	logic [ROUTE_AW-1:0]      host_idx;
	logic [ROUTE_AW-1:0]      dest_idx;
	logic                     load_ok;
	logic                     route_we;
	logic                     dest_in_range;

	// holdoff table: tags and valid bits in flops, times in a memory
	logic [HOLDOFF_ENTRIES-1:0] ho_vld_q;
	logic [MAC_W-1:0]           ho_mac_q [HOLDOFF_ENTRIES];
	logic [TICK_W-1:0]          ho_time_mem [HOLDOFF_ENTRIES];

	// search results
	logic             hit;
	logic [HO_AW-1:0] hit_idx;
	logic             free_found;
	logic [HO_AW-1:0] free_idx;

	// lookup results, registered from the lookup state
	logic              hit_s2;
	logic [HO_AW-1:0]  hit_idx_s2;
	logic              free_s2;
	logic [HO_AW-1:0]  free_idx_s2;
	logic              route_ok_s2;
	logic [PORT_W-1:0] route_rd_s2;
	logic [TICK_W-1:0] time_rd_s2;

	// decide stage
	logic              fb;
	logic [TICK_W-1:0] elapsed;
	logic              pass;
	logic              time_we;
	logic [HO_AW-1:0]  time_waddr;
	logic              tag_we;
	logic              fwd;

	// result registers
	logic              done_q;
	logic              forwarded_q;
	logic [PORT_W-1:0] out_port_q;
	logic              is_feedback_q;
	logic              held_off_q;
	logic [MAC_W-1:0]  out_src_mac_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_index_q    <= SWITCH_INDEX_RST;
			feedback_length_q <= FEEDBACK_LENGTH_RST;
			holdoff_ticks_q   <= HOLDOFF_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SWITCH_INDEX:    switch_index_q    <= cfg_wdata[SWIDX_W-1:0];
				CFG_FEEDBACK_LENGTH: feedback_length_q <= cfg_wdata[LEN_W-1:0];
				CFG_HOLDOFF_TICKS:   holdoff_ticks_q   <= cfg_wdata[TICK_W-1:0];
				default: ; // writes beyond the register list are ignored
			endcase
		end
	end

	// sequencer: idle, lookup (search and memory reads), decide (write-back)
	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= action;
			dest_mac_s1   <= dest_mac;
			src_mac_s1    <= src_mac;
			pkt_length_s1 <= pkt_length;
			host_id_s1    <= host_id;
			route_port_s1 <= route_port;
			now_ticks_s1  <= now_ticks;
		end
	end

	// route table access in the lookup cycle
	assign host_idx      = host_id_s1[ROUTE_AW-1:0];
	assign dest_idx      = dest_mac_s1[ROUTE_AW-1:0];
	assign dest_in_range = ({1'b0, dest_mac_s1[7:0]} < 9'(ROUTE_ENTRIES));
	// first load for a host wins; out-of-range hosts and ports are dropped
	assign load_ok       = ({1'b0, host_id_s1} < 9'(ROUTE_ENTRIES))
	                    && ({3'b000, route_port_s1} < 7'(NUM_PORTS))
	                    && !route_vld_q[host_idx];
	assign route_we      = (state_q == ST_LOOKUP) && (action_s1 == ACT_LOAD) && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_vld_q <= '0;
		end else if (route_we) begin
			route_vld_q[host_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (route_we) begin
			route_mem[host_idx] <= route_port_s1;
		end
		route_rd_s2 <= route_mem[dest_idx];
	end

	// destination tag search: lowest matching entry and lowest free entry
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < HOLDOFF_ENTRIES; i++) begin
			if (!hit && ho_vld_q[i] && (ho_mac_q[i] == dest_mac_s1)) begin
				hit     = 1'b1;
				hit_idx = HO_AW'(i);
			end
			if (!free_found && !ho_vld_q[i]) begin
				free_found = 1'b1;
				free_idx   = HO_AW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			hit_s2      <= hit;
			hit_idx_s2  <= hit_idx;
			free_s2     <= free_found;
			free_idx_s2 <= free_idx;
			route_ok_s2 <= dest_in_range && route_vld_q[dest_idx];
		end
	end

	// decide: holdoff comparison with wrapping difference, then write-back
	assign fb         = (pkt_length_s1 == feedback_length_q);
	assign elapsed    = now_ticks_s1 - time_rd_s2;
	assign pass       = !fb || !hit_s2 || (elapsed > holdoff_ticks_q);
	// a passing recorded destination refreshes its time; a new one takes a free entry if any
	assign tag_we     = (state_q == ST_DECIDE) && (action_s1 == ACT_PACKET) && fb
	                 && !hit_s2 && free_s2;
	assign time_we    = ((state_q == ST_DECIDE) && (action_s1 == ACT_PACKET) && fb
	                 && hit_s2 && pass) || tag_we;
	assign time_waddr = hit_s2 ? hit_idx_s2 : free_idx_s2;
	assign fwd        = (action_s1 == ACT_PACKET) && pass && route_ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ho_vld_q <= '0;
		end else if (tag_we) begin
			ho_vld_q[free_idx_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			ho_mac_q[free_idx_s2] <= dest_mac_s1;
		end
	end

	// time memory: read in lookup, written back in decide
	always_ff @(posedge clk) begin
		if (time_we) begin
			ho_time_mem[time_waddr] <= now_ticks_s1;
		end
		time_rd_s2 <= ho_time_mem[hit_idx];
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DECIDE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			forwarded_q   <= fwd;
			out_port_q    <= fwd ? route_rd_s2 : '0;
			is_feedback_q <= (action_s1 == ACT_PACKET) && fb;
			held_off_q    <= (action_s1 == ACT_PACKET) && !pass;
			if (action_s1 == ACT_LOAD) begin
				out_src_mac_q <= '0;
			end else if (fb) begin
				out_src_mac_q <= {FB_MAC_HI, switch_index_q, FB_MAC_LO};
			end else begin
				out_src_mac_q <= src_mac_s1;
			end
		end
	end

	assign done        = done_q;
	assign forwarded   = forwarded_q;
	assign out_port    = out_port_q;
	assign is_feedback = is_feedback_q;
	assign held_off    = held_off_q;
	assign out_src_mac = out_src_mac_q;

endmodule
